FILE: design/day_night_automaton_step_assert.svh
// Assertion macros for the day/night automaton.
`ifndef DAY_NIGHT_AUTOMATON_STEP_ASSERT_SVH
`define DAY_NIGHT_AUTOMATON_STEP_ASSERT_SVH

// Asserts that a condition implies another condition in the same cycle.
`define DN_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// Asserts that a condition implies another condition in the next cycle.
`define DN_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

FILE: design/dna_pkg.sv
package dna_pkg;

    localparam int BOARD_WIDTH_DEF  = 64;
    localparam int BOARD_HEIGHT_DEF = 64;
    localparam int COORD_W          = 6;
    localparam int MASK_W           = 9;
    localparam int OP_W             = 2;
    localparam int CFG_IDX_W        = 1;

    localparam logic [MASK_W-1:0] BIRTH_RESET   = 9'd456;
    localparam logic [MASK_W-1:0] SURVIVE_RESET = 9'd472;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_ADVANCE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] REG_BIRTH   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SURVIVE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RUN,
        ST_READ,
        ST_OUT
    } state_t;

endpackage

FILE: design/dna_cell.sv
module dna_cell
(
    input  logic                          up,
    input  logic [2:0]                    mid3,
    input  logic                          dn,
    input  logic                          up_l,
    input  logic                          up_r,
    input  logic                          dn_l,
    input  logic                          dn_r,
    input  logic [dna_pkg::MASK_W-1:0]    birth_mask,
    input  logic [dna_pkg::MASK_W-1:0]    survive_mask,
    output logic                          next_val
);
    logic [3:0] count;

    assign count = 4'(up) + 4'(dn) + 4'(up_l) + 4'(up_r) + 4'(dn_l) + 4'(dn_r)
                 + 4'(mid3[0]) + 4'(mid3[2]);
    assign next_val = mid3[1] ? survive_mask[count] : birth_mask[count];
endmodule

FILE: design/dna_row_unit.sv
module dna_row_unit #(
    parameter int BOARD_WIDTH = dna_pkg::BOARD_WIDTH_DEF
)
(
    input  logic [BOARD_WIDTH-1:0]        row_up,
    input  logic [BOARD_WIDTH-1:0]        row_mid,
    input  logic [BOARD_WIDTH-1:0]        row_dn,
    input  logic [dna_pkg::MASK_W-1:0]    birth_mask,
    input  logic [dna_pkg::MASK_W-1:0]    survive_mask,
    output logic [BOARD_WIDTH-1:0]        row_new
);
    genvar c;
    generate
        for (c = 0; c < BOARD_WIDTH; c++) begin : g_cell
            localparam int CL = (c == 0) ? BOARD_WIDTH - 1 : c - 1;
            localparam int CR = (c == BOARD_WIDTH - 1) ? 0 : c + 1;
            dna_cell u_cell (
                .up           (row_up[c]),
                .mid3         ({row_mid[CR], row_mid[c], row_mid[CL]}),
                .dn           (row_dn[c]),
                .up_l         (row_up[CL]),
                .up_r         (row_up[CR]),
                .dn_l         (row_dn[CL]),
                .dn_r         (row_dn[CR]),
                .birth_mask   (birth_mask),
                .survive_mask (survive_mask),
                .next_val     (row_new[c])
            );
        end
    endgenerate
endmodule

FILE: design/day_night_automaton_step.sv
// Day and Night automaton on a toroidal board held in two row memories.
// s_axis: tdata {write_value, cell_row, cell_col, operation}; one item at a time.
// m_axis: tdata {completed_operation, read_value}; one result per item.
// operation 3 is dropped with no result.
// cfg: cfg_valid/cfg_ready with cfg_index (0 birth, 1 survive) and cfg_data.
// Advance: row BOARD_HEIGHT-1 and row 0 are preloaded, then one row word per
// cycle is read from the active memory, passed through a row of rule cells
// with a three-row window, and written to the other memory.
// A new item is taken only after the result has left the output register.
// Reset clears control, sets the Day and Night masks, and starts a clearing
// pass over all BOARD_HEIGHT rows of both memories during which s_axis_tready
// stays low. A stalled m_axis holds its result and blocks further items.
module day_night_automaton_step #(
    parameter int BOARD_WIDTH  = dna_pkg::BOARD_WIDTH_DEF,
    parameter int BOARD_HEIGHT = dna_pkg::BOARD_HEIGHT_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // operation[1:0], cell_col[7:2], cell_row[13:8], write_value[14], pad
    input  logic [15:0]                   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_value[0], completed_operation[2:1], pad
    output logic [7:0]                    m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dna_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dna_pkg::MASK_W-1:0]    cfg_data
);
    localparam int RW = (BOARD_HEIGHT > 1) ? $clog2(BOARD_HEIGHT) : 1;
    localparam int CW = $clog2(BOARD_WIDTH + 1);

    logic [BOARD_WIDTH-1:0] mem_a [BOARD_HEIGHT];
    logic [BOARD_WIDTH-1:0] mem_b [BOARD_HEIGHT];

    dna_pkg::state_t state_reg, state_next;
    logic                       active_reg;
    logic                       clr_reg;
    logic [RW-1:0]              cnt_reg;
    logic [dna_pkg::MASK_W-1:0] birth_reg, survive_reg;
    dna_pkg::op_t               op_reg;
    logic [dna_pkg::COORD_W-1:0] col_reg, row_reg;
    logic                       wv_reg;
    logic                       rv_reg;
    logic [BOARD_WIDTH-1:0]     rd_reg;
    logic [BOARD_WIDTH-1:0]     row0_reg, up_reg, mid_reg;
    logic [RW-1:0]              rd_idx;
    logic [RW:0]                wr_cnt_reg;
    logic                       in_acc, out_acc, on_board, load_done;
    logic [BOARD_WIDTH-1:0]     row_new, dn_row;
    dna_pkg::op_t               in_op;
    logic                       m_axis_tvalid_q;
    logic [BOARD_WIDTH-1:0]     wr_word;
    logic [CW-1:0]              col_idx;
    logic [BOARD_WIDTH-1:0]     wr_cur;

    assign in_op    = dna_pkg::op_t'(s_axis_tdata[1:0]);
    assign in_acc   = s_axis_tvalid && s_axis_tready;
    assign out_acc  = m_axis_tvalid && m_axis_tready;
    assign cfg_ready = 1'b1;
    assign on_board = ({1'b0, col_reg} < (dna_pkg::COORD_W+1)'(BOARD_WIDTH))
                   && ({5'd0, row_reg} < 11'(BOARD_HEIGHT));
    assign load_done = (cnt_reg == RW'(2));
    // Idle: row of the incoming item. Advance: row cnt_reg-1, wrapped.
    assign rd_idx   = (state_reg == dna_pkg::ST_IDLE) ? RW'(s_axis_tdata[13:8])
                    : (cnt_reg == '0) ? RW'(BOARD_HEIGHT - 1) : cnt_reg - RW'(1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dna_pkg::ST_IDLE:
                if (in_acc)
                begin
                    case (in_op)
                        dna_pkg::OP_WRITE:   state_next = dna_pkg::ST_OUT;
                        dna_pkg::OP_READ:    state_next = dna_pkg::ST_READ;
                        dna_pkg::OP_ADVANCE: state_next = dna_pkg::ST_LOAD;
                        default:             state_next = dna_pkg::ST_IDLE;
                    endcase
                end
            dna_pkg::ST_LOAD: if (load_done) state_next = dna_pkg::ST_RUN;
            dna_pkg::ST_RUN:
                if (wr_cnt_reg == (RW+1)'(BOARD_HEIGHT - 1)) state_next = dna_pkg::ST_OUT;
            dna_pkg::ST_READ: state_next = dna_pkg::ST_OUT;
            dna_pkg::ST_OUT:  if (out_acc) state_next = dna_pkg::ST_IDLE;
            default:          state_next = dna_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready = (state_reg == dna_pkg::ST_IDLE) && !clr_reg;
        m_axis_tvalid = (state_reg == dna_pkg::ST_OUT);
        m_axis_tdata  = {5'd0, op_reg, rv_reg};
    end

    // Bottom neighbor of the row being written: next read row, or row 0 at wrap.
    assign dn_row = (wr_cnt_reg == (RW+1)'(BOARD_HEIGHT - 1)) ? row0_reg : rd_reg;

    dna_row_unit #(.BOARD_WIDTH(BOARD_WIDTH)) u_row (
        .row_up       (up_reg),
        .row_mid      (mid_reg),
        .row_dn       (dn_row),
        .birth_mask   (birth_reg),
        .survive_mask (survive_reg),
        .row_new      (row_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dna_pkg::ST_IDLE;
            active_reg  <= 1'b0;
            clr_reg     <= 1'b1;
            cnt_reg     <= '0;
            wr_cnt_reg  <= '0;
            birth_reg   <= dna_pkg::BIRTH_RESET;
            survive_reg <= dna_pkg::SURVIVE_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    dna_pkg::REG_BIRTH:   birth_reg   <= cfg_data;
                    dna_pkg::REG_SURVIVE: survive_reg <= cfg_data;
                    default:              ;
                endcase
            end
            if (clr_reg)
            begin
                cnt_reg <= (cnt_reg == RW'(BOARD_HEIGHT - 1)) ? '0 : cnt_reg + RW'(1);
                if (cnt_reg == RW'(BOARD_HEIGHT - 1)) clr_reg <= 1'b0;
            end
            else if (state_reg == dna_pkg::ST_IDLE)
            begin
                cnt_reg    <= '0;
                wr_cnt_reg <= '0;
            end
            else if (state_reg == dna_pkg::ST_LOAD)
                cnt_reg <= (cnt_reg == RW'(BOARD_HEIGHT - 1)) ? '0 : cnt_reg + RW'(1);
            else if (state_reg == dna_pkg::ST_RUN)
            begin
                cnt_reg <= (cnt_reg == RW'(BOARD_HEIGHT - 1)) ? '0 : cnt_reg + RW'(1);
                wr_cnt_reg <= wr_cnt_reg + (RW+1)'(1);
                if (state_next == dna_pkg::ST_OUT) active_reg <= !active_reg;
            end
        end
    end

    // Memories: one registered read port, one write port each.
    always_ff @(posedge clk)
    begin
        rd_reg <= active_reg ? mem_b[rd_idx] : mem_a[rd_idx];
        if (clr_reg)
        begin
            mem_a[cnt_reg] <= '0;
            mem_b[cnt_reg] <= '0;
        end
        else if (state_reg == dna_pkg::ST_RUN)
        begin
            if (active_reg) mem_a[wr_cnt_reg[RW-1:0]] <= row_new;
            else            mem_b[wr_cnt_reg[RW-1:0]] <= row_new;
        end
        else if (state_reg == dna_pkg::ST_OUT && op_reg == dna_pkg::OP_WRITE && on_board
                 && !m_axis_tvalid_q)
        begin
            if (active_reg) mem_b[RW'(row_reg)] <= wr_word;
            else            mem_a[RW'(row_reg)] <= wr_word;
        end
    end

    assign col_idx = CW'(col_reg);
    assign wr_cur  = rd_reg;
    always_comb
    begin
        wr_word = wr_cur;
        wr_word[col_idx[$clog2(BOARD_WIDTH)-1:0]] = wv_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) m_axis_tvalid_q <= 1'b0;
        else        m_axis_tvalid_q <= m_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            op_reg  <= in_op;
            col_reg <= s_axis_tdata[7:2];
            row_reg <= s_axis_tdata[13:8];
            wv_reg  <= s_axis_tdata[14];
            rv_reg  <= 1'b0;
        end
        if (state_reg == dna_pkg::ST_READ)
            rv_reg <= on_board ? rd_reg[col_idx[$clog2(BOARD_WIDTH)-1:0]] : 1'b0;
        if (state_reg == dna_pkg::ST_LOAD)
        begin
            if (cnt_reg == RW'(1))
                up_reg <= rd_reg;
            else if (cnt_reg == RW'(2))
            begin
                row0_reg <= rd_reg;
                mid_reg  <= rd_reg;
            end
        end
        if (state_reg == dna_pkg::ST_RUN)
        begin
            up_reg  <= mid_reg;
            mid_reg <= dn_row;
        end
    end

    `include "day_night_automaton_step_assert.svh"

    `DN_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != dna_pkg::ST_IDLE, !s_axis_tready)
    `DN_ASSERT_IMPL(a_no_accept_clr, clk, rst_n, clr_reg, !s_axis_tready)
    `DN_ASSERT_NEXT(a_out_holds, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
endmodule
